[design/cau_pkg.sv]
// cau_pkg: widths, codes, item and stage types, and shared arithmetic helpers
// for the complex arithmetic unit. No dependencies; every other file uses it.
`default_nettype none

package cau_pkg;

	localparam int DW     = 32;          // operand and result width
	localparam int FW     = 16;          // fraction bits
	localparam int CSTEPS = 16;          // CORDIC iterations
	localparam int GUARD  = 8;           // CORDIC guard bits
	localparam int AFRAC  = 24;          // angle accumulator fraction bits (degrees)
	localparam int PW     = 2 * DW;      // exact product width
	localparam int QB     = DW + 1;      // quotient bits produced by the divider
	localparam int DLW    = PW + DW - FW;// width of the divide overflow bound
	localparam int XW     = DW + GUARD + 3;
	localparam int ZW     = 33;
	localparam int HW     = XW - 1 - 32; // upper slice of x for the gain multiply

	localparam int NST  = QB + 5;          // back pipeline depth
	localparam int CLAT = CSTEPS + 3;      // register depth of the CORDIC unit
	localparam int CD   = NST - 1 - CLAT;  // delay that aligns CORDIC results

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [31:0] KGAIN = 32'd2608131496;  // 0.60725293500888 in Q0.32

	typedef logic signed [DW-1:0] data_t;

	localparam data_t VMAX = {1'b0, {(DW-1){1'b1}}};
	localparam data_t VMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [PW-1:0] VMAX_W = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// atan(2^-i) in degrees, Q8.24
	localparam logic signed [ZW-1:0] ATAN_DEG [32] = '{
		33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
		33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
		33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367,
		33'sd234684,    33'sd117342,    33'sd58671,     33'sd29335,
		33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
		33'sd917,       33'sd458,       33'sd229,       33'sd115,
		33'sd57,        33'sd29,        33'sd14,        33'sd7,
		33'sd4,         33'sd2,         33'sd1,         33'sd0
	};

	typedef enum logic [2:0] {
		MODE_ADD = 3'd0,
		MODE_SUB = 3'd1,
		MODE_MUL = 3'd2,
		MODE_DIV = 3'd3,
		MODE_MAG = 3'd4,
		MODE_ANG = 3'd5,
		MODE_EQ  = 3'd6
	} mode_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_DIVZ,
		OP_MAG,
		OP_ANG,
		OP_EQ
	} op_t;

	typedef struct packed {
		op_t   op;
		data_t a_re;
		data_t a_im;
		data_t b_re;
		data_t b_im;
	} item_t;

	typedef struct packed {
		op_t   op;
		data_t re;
		data_t im;
		logic  eq;
		logic  sat;
	} ctx_t;

	typedef struct packed {
		data_t v;
		logic  sat;
	} sat_t;

	typedef struct packed {
		data_t mag;
		logic  mag_sat;
		data_t ang;
	} cordic_res_t;

	typedef struct packed {
		logic [PW-1:0] p;    // partial remainder
		logic [QB-1:0] n;    // dividend bits still to bring down
		logic [QB-1:0] q;
		logic          neg;
		logic          ovf;
	} dlane_t;

	typedef struct packed {
		data_t      re;
		data_t      im;
		logic       eq;
		logic [1:0] status;
	} out_t;

	// saturate a sign and magnitude pair to the result width
	function automatic sat_t sm_sat(input logic neg, input logic [PW-1:0] mag);
		sat_t r;
		r.sat = 1'b0;
		if (neg) begin
			if (mag > VMAX_W + PW'(1)) begin
				r.v   = VMIN;
				r.sat = 1'b1;
			end else begin
				r.v = data_t'(DW'(0) - mag[DW-1:0]);
			end
		end else begin
			if (mag > VMAX_W) begin
				r.v   = VMAX;
				r.sat = 1'b1;
			end else begin
				r.v = data_t'(mag[DW-1:0]);
			end
		end
		return r;
	endfunction

	// saturate a sum that grew by one bit
	function automatic sat_t sat_sum(input logic signed [DW:0] s);
		sat_t r;
		if (s[DW] != s[DW-1]) begin
			r.v   = s[DW] ? VMIN : VMAX;
			r.sat = 1'b1;
		end else begin
			r.v   = data_t'(s[DW-1:0]);
			r.sat = 1'b0;
		end
		return r;
	endfunction

	// one restoring division step: bring down a bit, subtract if it fits
	function automatic dlane_t div_step(input dlane_t d, input logic [PW-1:0] den);
		logic [PW:0] pin;
		logic [PW:0] dif;
		dlane_t      r;
		pin = {d.p, d.n[QB-1]};
		dif = pin - {1'b0, den};
		r   = d;
		r.n = d.n << 1;
		if (!dif[PW]) begin
			r.p = dif[PW-1:0];
			r.q = {d.q[QB-2:0], 1'b1};
		end else begin
			r.p = pin[PW-1:0];
			r.q = {d.q[QB-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[design/cau_in_if.sv]
// cau_in_if: request channel of the complex arithmetic unit (mode, operands).
// Depends on cau_pkg for widths.
`default_nettype none

interface cau_in_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    mode;
	logic signed [cau_pkg::DW-1:0] a_re;
	logic signed [cau_pkg::DW-1:0] a_im;
	logic signed [cau_pkg::DW-1:0] b_re;
	logic signed [cau_pkg::DW-1:0] b_im;

	modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
	modport sink (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

`default_nettype wire

[design/cau_out_if.sv]
// cau_out_if: result channel of the complex arithmetic unit.
// Depends on cau_pkg for widths.
`default_nettype none

interface cau_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [cau_pkg::DW-1:0] res_re;
	logic signed [cau_pkg::DW-1:0] res_im;
	logic                          is_equal;
	logic [1:0]                    status;

	modport source (output valid, res_re, res_im, is_equal, status, input ready);
	modport sink (input valid, res_re, res_im, is_equal, status, output ready);
endinterface

`default_nettype wire

[design/cau_front.sv]
// cau_front: accepts requests, decodes the mode and flags the zero-operand
// cases into an operation class. Depends on cau_pkg and cau_in_if.
`default_nettype none

module cau_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cau_in_if.sink             operands,
	output cau_pkg::item_t     item,
	output logic               item_valid,
	input  wire logic          item_ready
);

	cau_pkg::item_t cls;
	cau_pkg::item_t item_s1;
	logic           v_q;
	logic           a_zero;
	logic           b_zero;

	assign a_zero = (operands.a_re == '0) && (operands.a_im == '0);
	assign b_zero = (operands.b_re == '0) && (operands.b_im == '0);

	always_comb begin
		cls.a_re = operands.a_re;
		cls.a_im = operands.a_im;
		cls.b_re = operands.b_re;
		cls.b_im = operands.b_im;
		unique case (operands.mode)
			cau_pkg::MODE_ADD: cls.op = cau_pkg::OP_ADD;
			cau_pkg::MODE_SUB: cls.op = cau_pkg::OP_SUB;
			cau_pkg::MODE_MUL: cls.op = cau_pkg::OP_MUL;
			cau_pkg::MODE_DIV: cls.op = b_zero ? cau_pkg::OP_DIVZ : cau_pkg::OP_DIV;
			cau_pkg::MODE_MAG: cls.op = cau_pkg::OP_MAG;
			// angle of the origin is defined as zero
			cau_pkg::MODE_ANG: cls.op = a_zero ? cau_pkg::OP_NOP : cau_pkg::OP_ANG;
			cau_pkg::MODE_EQ:  cls.op = cau_pkg::OP_EQ;
			default:           cls.op = cau_pkg::OP_NOP;
		endcase
	end

	assign operands.ready = !v_q || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (operands.ready) begin
			v_q <= operands.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (operands.ready && operands.valid) begin
			item_s1 <= cls;
		end
	end

	assign item       = item_s1;
	assign item_valid = v_q;

endmodule

`default_nettype wire

[design/cau_fifo.sv]
// cau_fifo: short queue of classified requests between front and back.
// Depends on cau_pkg.
`default_nettype none

module cau_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire cau_pkg::item_t push_data,
	output logic                full,
	input  wire logic           pop,
	output cau_pkg::item_t      pop_data,
	output logic                empty
);

	cau_pkg::item_t                mem_q [cau_pkg::FIFO_DEPTH];
	logic [cau_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [cau_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [cau_pkg::FIFO_AW:0]     cnt_q;
	logic                          do_push;
	logic                          do_pop;

	assign full     = (cnt_q == (cau_pkg::FIFO_AW + 1)'(cau_pkg::FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[design/cau_cordic.sv]
// cau_cordic: pipelined CORDIC vectoring of operand a, one iteration a stage,
// then gain correction and angle rounding. Depends on cau_pkg.
`default_nettype none

module cau_cordic (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire cau_pkg::data_t    a_re,
	input  wire cau_pkg::data_t    a_im,
	output cau_pkg::cordic_res_t   res
);

	localparam logic signed [cau_pkg::ZW-1:0] Z90  = cau_pkg::ZW'(90 * (2 ** cau_pkg::AFRAC));
	localparam logic signed [cau_pkg::ZW-1:0] ZLIM = Z90 <<< 1;
	localparam logic signed [cau_pkg::ZW-1:0] ZHALF =
		cau_pkg::ZW'(1) <<< (cau_pkg::AFRAC - cau_pkg::FW - 1);

	logic signed [cau_pkg::XW-1:0] x_s [cau_pkg::CSTEPS+1];
	logic signed [cau_pkg::XW-1:0] y_s [cau_pkg::CSTEPS+1];
	logic signed [cau_pkg::ZW-1:0] z_s [cau_pkg::CSTEPS+1];

	logic signed [cau_pkg::XW-1:0] xg;
	logic signed [cau_pkg::XW-1:0] yg;

	logic [cau_pkg::HW+31:0]       hi_g;
	logic [63:0]                   lo_g;
	logic signed [cau_pkg::ZW-1:0] z_g;
	logic [cau_pkg::XW-2:0]        xp;

	logic [cau_pkg::HW+32:0]       hs;
	logic [cau_pkg::HW+32:0]       mrnd;
	logic signed [cau_pkg::ZW-1:0] zc;
	logic signed [cau_pkg::ZW-1:0] zr;
	cau_pkg::sat_t                 ms;

	assign xg = cau_pkg::XW'(a_re) <<< cau_pkg::GUARD;
	assign yg = cau_pkg::XW'(a_im) <<< cau_pkg::GUARD;

	// left half plane: turn by 90 degrees first
	always_ff @(posedge clk) begin
		if (en) begin
			if (xg < 0) begin
				if (yg >= 0) begin
					x_s[0] <= yg;
					y_s[0] <= -xg;
					z_s[0] <= Z90;
				end else begin
					x_s[0] <= -yg;
					y_s[0] <= xg;
					z_s[0] <= -Z90;
				end
			end else begin
				x_s[0] <= xg;
				y_s[0] <= yg;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < cau_pkg::CSTEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + cau_pkg::ATAN_DEG[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - cau_pkg::ATAN_DEG[i];
				end
			end
		end
	end

	assign xp = (x_s[cau_pkg::CSTEPS] < 0) ? '0 : x_s[cau_pkg::CSTEPS][cau_pkg::XW-2:0];

	// gain multiply split into two partial products
	always_ff @(posedge clk) begin
		if (en) begin
			hi_g <= (cau_pkg::HW + 32)'(xp[cau_pkg::XW-2:32]) * (cau_pkg::HW + 32)'(cau_pkg::KGAIN);
			lo_g <= 64'(xp[31:0]) * 64'(cau_pkg::KGAIN);
			z_g  <= z_s[cau_pkg::CSTEPS];
		end
	end

	always_comb begin
		hs   = (cau_pkg::HW + 33)'(hi_g) + (cau_pkg::HW + 33)'(lo_g[63:32]);
		mrnd = (hs + (cau_pkg::HW + 33)'(2 ** (cau_pkg::GUARD - 1))) >> cau_pkg::GUARD;
		ms   = cau_pkg::sm_sat(1'b0, cau_pkg::PW'(mrnd));
		if (z_g > ZLIM) begin
			zc = ZLIM;
		end else if (z_g < -ZLIM) begin
			zc = -ZLIM;
		end else begin
			zc = z_g;
		end
		zr = (zc + ZHALF) >>> (cau_pkg::AFRAC - cau_pkg::FW);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.mag     <= ms.v;
			res.mag_sat <= ms.sat;
			res.ang     <= cau_pkg::data_t'(cau_pkg::DW'(zr));
		end
	end

endmodule

`default_nettype wire

[design/cau_back.sv]
// cau_back: execution pipeline. Products, sums, restoring divider (one
// quotient bit a stage), CORDIC unit and result merge. Depends on cau_pkg,
// cau_out_if and cau_cordic.
`default_nettype none

module cau_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cau_pkg::item_t head,
	input  wire logic           head_valid,
	output logic                pop,
	cau_out_if.source           results
);

	localparam int PW  = cau_pkg::PW;
	localparam int QB  = cau_pkg::QB;
	localparam int NST = cau_pkg::NST;
	localparam int CD  = cau_pkg::CD;
	localparam logic [PW-1:0] HALF = PW'(1) << (cau_pkg::FW - 1);

	logic             en;
	logic [NST:1]     vld_q;

	// stage 1
	logic signed [PW-1:0] rr_s1, ii_s1, ri_s1, ir_s1, bb_s1, cc_s1;
	cau_pkg::ctx_t        ctx_in;
	cau_pkg::ctx_t        ctx_s1;
	cau_pkg::sat_t        sr, si;

	// stage 2
	logic signed [PW:0]   nre_s2, nim_s2;
	logic [PW-1:0]        den_s2;
	cau_pkg::ctx_t        ctx_s2;

	// stage 3
	logic [PW-1:0]        mre_s3, mim_s3, den_s3;
	logic                 nre_neg_s3, nim_neg_s3;
	logic [cau_pkg::DLW-1:0] dlim_s3;
	cau_pkg::ctx_t        ctx_s3;

	// stage 4 onward
	cau_pkg::ctx_t        ctx4;
	cau_pkg::sat_t        mr, mi;
	cau_pkg::dlane_t      dre_s [QB+1];
	cau_pkg::dlane_t      dim_s [QB+1];
	logic [PW-1:0]        den_s [QB+1];
	cau_pkg::ctx_t        ctx_s [QB+1];

	cau_pkg::cordic_res_t cres;
	cau_pkg::cordic_res_t cd_s [1:CD];

	cau_pkg::sat_t        dr, di;
	logic [QB:0]          qre, qim;
	cau_pkg::out_t        out_d;
	cau_pkg::out_t        out_q;
	logic                 fsat;

	assign en  = !vld_q[NST] || results.ready;
	assign pop = en && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-1:1], head_valid};
		end
	end

	// add, subtract and compare finish in the first stage
	always_comb begin
		ctx_in.op  = head.op;
		ctx_in.re  = '0;
		ctx_in.im  = '0;
		ctx_in.eq  = 1'b0;
		ctx_in.sat = 1'b0;
		sr = cau_pkg::sat_sum((cau_pkg::DW + 1)'(head.a_re) + (cau_pkg::DW + 1)'(head.b_re));
		si = cau_pkg::sat_sum((cau_pkg::DW + 1)'(head.a_im) + (cau_pkg::DW + 1)'(head.b_im));
		unique case (head.op)
			cau_pkg::OP_ADD: begin
				sr = cau_pkg::sat_sum((cau_pkg::DW + 1)'(head.a_re) + (cau_pkg::DW + 1)'(head.b_re));
				si = cau_pkg::sat_sum((cau_pkg::DW + 1)'(head.a_im) + (cau_pkg::DW + 1)'(head.b_im));
				ctx_in.re  = sr.v;
				ctx_in.im  = si.v;
				ctx_in.sat = sr.sat | si.sat;
			end
			cau_pkg::OP_SUB: begin
				sr = cau_pkg::sat_sum((cau_pkg::DW + 1)'(head.a_re) - (cau_pkg::DW + 1)'(head.b_re));
				si = cau_pkg::sat_sum((cau_pkg::DW + 1)'(head.a_im) - (cau_pkg::DW + 1)'(head.b_im));
				ctx_in.re  = sr.v;
				ctx_in.im  = si.v;
				ctx_in.sat = sr.sat | si.sat;
			end
			cau_pkg::OP_EQ: begin
				ctx_in.eq = (head.a_re == head.b_re) && (head.a_im == head.b_im);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s1  <= PW'(head.a_re) * PW'(head.b_re);
			ii_s1  <= PW'(head.a_im) * PW'(head.b_im);
			ri_s1  <= PW'(head.a_re) * PW'(head.b_im);
			ir_s1  <= PW'(head.a_im) * PW'(head.b_re);
			bb_s1  <= PW'(head.b_re) * PW'(head.b_re);
			cc_s1  <= PW'(head.b_im) * PW'(head.b_im);
			ctx_s1 <= ctx_in;
		end
	end

	// product: (rr - ii, ri + ir); quotient numerator: (rr + ii, ir - ri)
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctx_s1.op == cau_pkg::OP_MUL) begin
				nre_s2 <= (PW + 1)'(rr_s1) - (PW + 1)'(ii_s1);
				nim_s2 <= (PW + 1)'(ri_s1) + (PW + 1)'(ir_s1);
			end else begin
				nre_s2 <= (PW + 1)'(rr_s1) + (PW + 1)'(ii_s1);
				nim_s2 <= (PW + 1)'(ir_s1) - (PW + 1)'(ri_s1);
			end
			den_s2 <= $unsigned(bb_s1) + $unsigned(cc_s1);
			ctx_s2 <= ctx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nre_neg_s3 <= nre_s2[PW];
			nim_neg_s3 <= nim_s2[PW];
			mre_s3     <= nre_s2[PW] ? PW'((PW + 1)'(0) - nre_s2) : nre_s2[PW-1:0];
			mim_s3     <= nim_s2[PW] ? PW'((PW + 1)'(0) - nim_s2) : nim_s2[PW-1:0];
			den_s3     <= den_s2;
			// integer quotient above 2^(DW-1-FW) saturates
			dlim_s3    <= (cau_pkg::DLW'(den_s2) << (cau_pkg::DW - 1 - cau_pkg::FW))
				+ cau_pkg::DLW'(den_s2);
			ctx_s3     <= ctx_s2;
		end
	end

	always_comb begin
		ctx4 = ctx_s3;
		mr   = cau_pkg::sm_sat(nre_neg_s3, (mre_s3 + HALF) >> cau_pkg::FW);
		mi   = cau_pkg::sm_sat(nim_neg_s3, (mim_s3 + HALF) >> cau_pkg::FW);
		if (ctx_s3.op == cau_pkg::OP_MUL) begin
			ctx4.re  = mr.v;
			ctx4.im  = mi.v;
			ctx4.sat = mr.sat | mi.sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[0]     <= ctx4;
			den_s[0]     <= den_s3;
			dre_s[0].p   <= mre_s3 >> cau_pkg::FW;
			dre_s[0].n   <= {mre_s3[cau_pkg::FW-1:0], (QB - cau_pkg::FW)'(0)};
			dre_s[0].q   <= '0;
			dre_s[0].neg <= nre_neg_s3;
			dre_s[0].ovf <= cau_pkg::DLW'(mre_s3) >= dlim_s3;
			dim_s[0].p   <= mim_s3 >> cau_pkg::FW;
			dim_s[0].n   <= {mim_s3[cau_pkg::FW-1:0], (QB - cau_pkg::FW)'(0)};
			dim_s[0].q   <= '0;
			dim_s[0].neg <= nim_neg_s3;
			dim_s[0].ovf <= cau_pkg::DLW'(mim_s3) >= dlim_s3;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				dre_s[k+1] <= cau_pkg::div_step(dre_s[k], den_s[k]);
				dim_s[k+1] <= cau_pkg::div_step(dim_s[k], den_s[k]);
				den_s[k+1] <= den_s[k];
				ctx_s[k+1] <= ctx_s[k];
			end
		end
	end

	cau_cordic u_cordic (
		.clk  (clk),
		.en   (en),
		.a_re (head.a_re),
		.a_im (head.a_im),
		.res  (cres)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cd_s[1] <= cres;
		end
	end

	for (genvar k = 1; k < CD; k++) begin : g_cd
		always_ff @(posedge clk) begin
			if (en) begin
				cd_s[k+1] <= cd_s[k];
			end
		end
	end

	// round the doubled-precision quotient half away from zero
	always_comb begin
		qre = ({1'b0, dre_s[QB].q} + (QB + 1)'(1)) >> 1;
		qim = ({1'b0, dim_s[QB].q} + (QB + 1)'(1)) >> 1;
		if (dre_s[QB].ovf) begin
			dr.v   = dre_s[QB].neg ? cau_pkg::VMIN : cau_pkg::VMAX;
			dr.sat = 1'b1;
		end else begin
			dr = cau_pkg::sm_sat(dre_s[QB].neg, PW'(qre));
		end
		if (dim_s[QB].ovf) begin
			di.v   = dim_s[QB].neg ? cau_pkg::VMIN : cau_pkg::VMAX;
			di.sat = 1'b1;
		end else begin
			di = cau_pkg::sm_sat(dim_s[QB].neg, PW'(qim));
		end

		out_d.re = ctx_s[QB].re;
		out_d.im = ctx_s[QB].im;
		out_d.eq = ctx_s[QB].eq;
		fsat     = ctx_s[QB].sat;
		unique case (ctx_s[QB].op)
			cau_pkg::OP_DIV: begin
				out_d.re = dr.v;
				out_d.im = di.v;
				fsat     = dr.sat | di.sat;
			end
			cau_pkg::OP_MAG: begin
				out_d.re = cd_s[CD].mag;
				fsat     = cd_s[CD].mag_sat;
			end
			cau_pkg::OP_ANG: begin
				out_d.re = cd_s[CD].ang;
			end
			default: begin
			end
		endcase

		priority if (ctx_s[QB].op == cau_pkg::OP_DIVZ) begin
			out_d.status = cau_pkg::ST_DIVZ;
		end else if (fsat) begin
			out_d.status = cau_pkg::ST_SAT;
		end else begin
			out_d.status = cau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_d;
		end
	end

	assign results.valid    = vld_q[NST];
	assign results.res_re   = out_q.re;
	assign results.res_im   = out_q.im;
	assign results.is_equal = out_q.eq;
	assign results.status   = out_q.status;

endmodule

`default_nettype wire

[design/complex_arithmetic_unit.sv]
// complex_arithmetic_unit: top level. Front decoder, request queue and
// execution pipeline. Depends on cau_pkg, both channel interfaces,
// cau_front, cau_fifo and cau_back.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-----------------------------------------
//  operands  | in  | valid / ready | mode, a_re, a_im, b_re, b_im
//  results   | out | valid / ready | res_re, res_im, is_equal, status
//
// One request per cycle sustained while results are taken. A request passes
// the front register, the queue and the back pipeline, whose length is
// set by the divider producing one quotient bit per stage (33 stages).
// Reset clears the valid bits, queue pointers and queue count only.
// A held result freezes the back pipeline; the 4-entry queue and the front
// register keep taking requests until they fill.
`default_nettype none

module complex_arithmetic_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	cau_in_if.sink    operands,
	cau_out_if.source results
);

	cau_pkg::item_t f_item;
	logic           f_valid;
	logic           q_full;
	cau_pkg::item_t q_head;
	logic           q_empty;
	logic           q_pop;

	cau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.operands   (operands),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (!q_full)
	);

	cau_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_data (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_head),
		.empty     (q_empty)
	);

	cau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (!q_empty),
		.pop        (q_pop),
		.results    (results)
	);

endmodule

`default_nettype wire

[test/cau_result_checker.sv]
`timescale 1ns / 100ps
// cau_result_checker: watches the request and result channels of the complex
// arithmetic unit, predicts each result and compares. Depends on cau_pkg and both interfaces.
`default_nettype none

module cau_result_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	cau_in_if         operands,
	cau_out_if        results,
	output int        fails,
	output int        pending,
	output int        checked
);
	import cau_pkg::*;

	localparam longint VMAX_L = 64'sd2147483647;
	localparam longint VMIN_L = -64'sd2147483648;
	localparam longint ZLIM   = 64'sd180 <<< AFRAC;

	out_t results_due[$];

	task automatic report(input string what, input longint got, input longint want);
		if (fails < 30)
			$display("MISMATCH %s: got %0d expected %0d (request %0d)", what, got, want, checked);
		fails++;
	endtask

	function automatic logic [63:0] umag(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clamp_mag(input bit neg, input logic [63:0] mag, inout bit hit);
		if (neg) begin
			if (mag > 64'd2147483648) begin
				hit = 1'b1;
				return VMIN_L;
			end
			return -longint'(mag);
		end
		if (mag > 64'(VMAX_L)) begin
			hit = 1'b1;
			return VMAX_L;
		end
		return longint'(mag);
	endfunction

	// exact p + q as sign and magnitude
	function automatic logic [63:0] signed_sum(input longint p, input longint q, output bit neg);
		logic [63:0] mp, mq;
		mp = umag(p);
		mq = umag(q);
		if ((p < 0) == (q < 0)) begin
			neg = p < 0;
			return mp + mq;
		end
		if (mp >= mq) begin
			neg = p < 0;
			return mp - mq;
		end
		neg = q < 0;
		return mq - mp;
	endfunction

	// rounded mag * 2^FW / den; an oversized quotient forces saturation
	function automatic logic [63:0] fixed_quotient(input logic [63:0] mag, input logic [63:0] den);
		logic [63:0] q, r;
		q = mag / den;
		r = mag % den;
		if (q > (64'd1 << (DW - 1 - FW)))
			return 64'(VMAX_L) + 64'd2;
		for (int i = 0; i < FW + 1; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

	function automatic void cordic_vector(input longint xi, input longint yi,
		output longint xo, output longint zo);
		longint x, y, z, t, dx, dy;
		x = xi * (64'sd1 <<< GUARD);
		y = yi * (64'sd1 <<< GUARD);
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 64'sd90 <<< AFRAC;
			end else begin
				x = -y;
				y = t;
				z = -(64'sd90 <<< AFRAC);
			end
		end
		for (int i = 0; i < CSTEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ATAN_DEG[i]);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ATAN_DEG[i]);
			end
		end
		xo = x;
		zo = z;
	endfunction

	function automatic logic [63:0] scale_gain(input logic [63:0] x);
		logic [63:0] kg, hi;
		kg = 64'(KGAIN);
		hi = (x >> 32) * kg + (((x & 64'hFFFF_FFFF) * kg) >> 32);
		return (hi + (64'd1 << (GUARD - 1))) >> GUARD;
	endfunction

	function automatic out_t predict_result(input logic [2:0] mode, input data_t ar_d,
		input data_t ai_d, input data_t br_d, input data_t bi_d);
		longint ar, ai, br, bi, re, im, xr, zr;
		logic [63:0] m1, m2, den;
		bit n1, n2, hit;
		out_t o;
		ar = ar_d; ai = ai_d; br = br_d; bi = bi_d;
		re = 0; im = 0; hit = 0;
		o.eq = 1'b0;
		o.status = ST_OK;
		case (mode)
			MODE_ADD: begin
				re = clamp_mag(ar + br < 0, umag(ar + br), hit);
				im = clamp_mag(ai + bi < 0, umag(ai + bi), hit);
			end
			MODE_SUB: begin
				re = clamp_mag(ar - br < 0, umag(ar - br), hit);
				im = clamp_mag(ai - bi < 0, umag(ai - bi), hit);
			end
			MODE_MUL: begin
				m1 = signed_sum(ar * br, -(ai * bi), n1);
				m2 = signed_sum(ar * bi, ai * br, n2);
				re = clamp_mag(n1, (m1 + (64'd1 << (FW - 1))) >> FW, hit);
				im = clamp_mag(n2, (m2 + (64'd1 << (FW - 1))) >> FW, hit);
			end
			MODE_DIV: begin
				if (br == 0 && bi == 0) begin
					o.status = ST_DIVZ;
				end else begin
					den = umag(br) * umag(br) + umag(bi) * umag(bi);
					m1 = signed_sum(ar * br, ai * bi, n1);
					m2 = signed_sum(ai * br, -(ar * bi), n2);
					re = clamp_mag(n1, fixed_quotient(m1, den), hit);
					im = clamp_mag(n2, fixed_quotient(m2, den), hit);
				end
			end
			MODE_MAG: begin
				cordic_vector(ar, ai, xr, zr);
				re = clamp_mag(1'b0, scale_gain(xr < 0 ? 64'd0 : 64'(xr)), hit);
			end
			MODE_ANG: begin
				if (ar != 0 || ai != 0) begin
					cordic_vector(ar, ai, xr, zr);
					if (zr > ZLIM) zr = ZLIM;
					if (zr < -ZLIM) zr = -ZLIM;
					zr = (zr + (64'sd1 <<< (AFRAC - FW - 1))) >>> (AFRAC - FW);
					re = clamp_mag(zr < 0, umag(zr), hit);
				end
			end
			MODE_EQ: o.eq = (ar == br && ai == bi);
			default: ;
		endcase
		if (hit && o.status == ST_OK)
			o.status = ST_SAT;
		o.re = data_t'(re);
		o.im = data_t'(im);
		return o;
	endfunction

	initial begin
		fails = 0;
		pending = 0;
		checked = 0;
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (operands.valid && operands.ready)
				results_due.push_back(predict_result(operands.mode, operands.a_re,
					operands.a_im, operands.b_re, operands.b_im));
			if (results.valid && results.ready) begin
				if (results_due.size() == 0) begin
					report("result with no request", 0, 0);
				end else begin
					want = results_due.pop_front();
					if (results.res_re !== want.re) report("res_re", results.res_re, want.re);
					if (results.res_im !== want.im) report("res_im", results.res_im, want.im);
					if (results.is_equal !== want.eq)
						report("is_equal", results.is_equal, want.eq);
					if (results.status !== want.status)
						report("status", results.status, want.status);
					checked++;
				end
			end
			pending = results_due.size();
		end
	end

endmodule

`default_nettype wire

[test/tb_complex_arithmetic_unit.sv]
`timescale 1ns / 100ps
// tb_complex_arithmetic_unit: drives directed and random requests into the
// complex arithmetic unit with random stalls. Depends on cau_pkg, interfaces, cau_result_checker.
`default_nettype none

module tb_complex_arithmetic_unit;
	import cau_pkg::*;

	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int N_RANDOM  = 1600;
	localparam int MAX_CYCLES = 400000;

	logic clk;
	logic arst_n;
	logic taken;
	bit   calm;
	int   fails, pending, checked, cycles;

	cau_in_if  operands ();
	cau_out_if results ();

	complex_arithmetic_unit dut (.clk(clk), .arst_n(arst_n), .operands(operands),
		.results(results));

	cau_result_checker checker_i (.clk(clk), .arst_n(arst_n), .operands(operands),
		.results(results), .fails(fails), .pending(pending), .checked(checked));

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) taken <= operands.valid && operands.ready;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("timeout with %0d results outstanding", pending);
			$display("complex_arithmetic_unit test failed");
			$finish;
		end
	end

	always @(negedge clk)
		if (arst_n)
			results.ready = calm || $urandom_range(99) >= 34;

	task automatic send(input logic [2:0] m, input data_t ar, input data_t ai,
		input data_t br, input data_t bi);
		operands.mode = m;
		operands.a_re = ar;
		operands.a_im = ai;
		operands.b_re = br;
		operands.b_im = bi;
		operands.valid = 1'b1;
		do @(negedge clk); while (!taken);
		if (!calm && $urandom_range(99) < 34) begin
			operands.valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	function automatic data_t pick_part(input int kind);
		case (kind)
			0: return data_t'($urandom);
			1: return data_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
			2: case ($urandom_range(4))
				0: return VMAX;
				1: return VMIN;
				2: return 0;
				3: return 1;
				default: return -1;
			endcase
			default: return data_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
		endcase
	endfunction

	initial begin
		logic [2:0] m;
		int kind;
		data_t ar, ai, br, bi;
		arst_n = 1'b0;
		cycles = 0;
		calm = 0;
		operands.valid = 1'b0;
		operands.mode = MODE_ADD;
		operands.a_re = 0;
		operands.a_im = 0;
		operands.b_re = 0;
		operands.b_im = 0;
		results.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corner cases: saturation, divide by zero, zero angle, axis angles, magnitude, equality, unused mode
		send(MODE_ADD, VMAX, VMIN, VMAX, VMIN);
		send(MODE_ADD, 32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, 32'sh0000_0001);
		send(MODE_SUB, VMIN, VMAX, VMAX, VMIN);
		send(MODE_SUB, 0, 0, -1, 1);
		send(MODE_MUL, VMIN, VMIN, VMIN, VMIN);
		send(MODE_MUL, VMAX, VMIN, VMAX, VMAX);
		send(MODE_MUL, 32'sh0003_0000, 32'sh0000_8000, -32'sh0001_0000, 32'sh0002_0000);
		send(MODE_DIV, 32'sh0001_0000, 32'sh0001_0000, 0, 0);
		send(MODE_DIV, VMAX, VMAX, 1, 0);
		send(MODE_DIV, VMIN, VMIN, VMIN, VMAX);
		send(MODE_DIV, 32'sh0004_0000, -32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000);
		send(MODE_MAG, VMIN, VMIN, 0, 0);
		send(MODE_MAG, VMAX, VMAX, 0, 0);
		send(MODE_MAG, 0, 0, 0, 0);
		send(MODE_MAG, 32'sh0003_0000, -32'sh0004_0000, 0, 0);
		send(MODE_ANG, 0, 0, 5, 5);
		send(MODE_ANG, -32'sh0001_0000, 0, 0, 0);
		send(MODE_ANG, -32'sh0001_0000, -1, 0, 0);
		send(MODE_ANG, 0, VMIN, 0, 0);
		send(MODE_ANG, VMIN, VMAX, 0, 0);
		send(MODE_EQ, VMIN, VMAX, VMIN, VMAX);
		send(MODE_EQ, 5, 7, 5, 6);
		send(MODE_UNUSED, VMAX, VMIN, 3, 4);

		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 700 && n < 950);
			m = ($urandom_range(49) == 0) ? MODE_UNUSED : 3'($urandom_range(6));
			kind = $urandom_range(3);
			ar = pick_part(kind);
			ai = pick_part($urandom_range(9) == 0 ? 2 : kind);
			br = pick_part($urandom_range(3));
			bi = pick_part($urandom_range(3));
			if (m == MODE_DIV && $urandom_range(9) == 0) begin
				br = 0;
				bi = 0;
			end
			if (m == MODE_EQ && $urandom_range(1) == 0) begin
				br = ar;
				if ($urandom_range(2) != 0) bi = ai;
			end
			send(m, ar, ai, br, bi);
		end
		operands.valid = 1'b0;
		calm = 0;

		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);

		$display("checked %0d results over all seven modes plus the unused code,", checked);
		$display("with saturation, divide by zero and random stalls on both channels");
		if (fails == 0 && pending == 0)
			$display("complex_arithmetic_unit test passed");
		else
			$display("complex_arithmetic_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire
